### design/swavg_pkg.sv
// shared types and codes for the sample window averager
package swavg_pkg;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;
   localparam int THRESHOLD_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREEFALL_AXIS      = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREEFALL_THRESHOLD = 4'd1;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   localparam axis_type AXIS_RESET = AXIS_Z;
   localparam logic signed [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 16'sd614;

   typedef struct packed {
      axis_type                           axis;
      logic signed [THRESHOLD_BITS-1:0]   threshold;
   } cfg_type;

endpackage

### design/sample_window_average_freefall_top.sv
// top level of the sample window averager with free-fall flag
//
// req channel: one beat per sensor sample (x, y, z acceleration and position
// ticks), valid/stall handshake. rsp channel: one beat per sample with the
// window means of all four channels and the free-fall flag of that sample.
// csr channel: register writes (index 0 free-fall axis, 1 threshold), always
// ready; write only while no sample is in flight.
//
// throughput: one sample per cycle unless rsp_stall holds the result, set by
// the running-sum update of one add and one subtract per channel. req beats
// pass the input register, then the result register. the window is a shift
// line of WINDOW_DEPTH entries; the oldest entry drops out at the last tap.
//
// reset clears both stage valids, the fill count and the sums, so the window
// reads as all zero, and loads axis z and threshold 614.
// when rsp_stall is high the result holds and req_stall follows in the same
// cycle once the input register holds a sample; an empty input register
// still takes one more beat.
module sample_window_average_freefall_top #(
   parameter int WINDOW_DEPTH  = 16,
   parameter int ACCEL_BITS    = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [ACCEL_BITS-1:0]            req_accel_x,
   input  logic signed [ACCEL_BITS-1:0]            req_accel_y,
   input  logic signed [ACCEL_BITS-1:0]            req_accel_z,
   input  logic [POSITION_BITS-1:0]                req_position_ticks,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [ACCEL_BITS-1:0]            rsp_mean_x,
   output logic signed [ACCEL_BITS-1:0]            rsp_mean_y,
   output logic signed [ACCEL_BITS-1:0]            rsp_mean_z,
   output logic [POSITION_BITS-1:0]                rsp_mean_position,
   output logic                                    rsp_free_fall,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [swavg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [swavg_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int SUM_A_BITS = ACCEL_BITS + $clog2(WINDOW_DEPTH) + 1;
   localparam int SUM_P_BITS = POSITION_BITS + $clog2(WINDOW_DEPTH);

   swavg_pkg::cfg_type             cfg;
   logic                           advance;
   logic                           out_ready;
   logic signed [ACCEL_BITS-1:0]   ax;
   logic signed [ACCEL_BITS-1:0]   ay;
   logic signed [ACCEL_BITS-1:0]   az;
   logic [POSITION_BITS-1:0]       pos;
   logic signed [SUM_A_BITS-1:0]   sum_x;
   logic signed [SUM_A_BITS-1:0]   sum_y;
   logic signed [SUM_A_BITS-1:0]   sum_z;
   logic [SUM_P_BITS-1:0]          sum_p;

   swavg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   swavg_in_stage #(
      .ACCEL_BITS    (ACCEL_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_in (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_accel_x        (req_accel_x),
      .req_accel_y        (req_accel_y),
      .req_accel_z        (req_accel_z),
      .req_position_ticks (req_position_ticks),
      .next_ready         (out_ready),
      .advance            (advance),
      .ax                 (ax),
      .ay                 (ay),
      .az                 (az),
      .pos                (pos)
   );

   swavg_window #(
      .WINDOW_DEPTH  (WINDOW_DEPTH),
      .ACCEL_BITS    (ACCEL_BITS),
      .POSITION_BITS (POSITION_BITS),
      .SUM_A_BITS    (SUM_A_BITS),
      .SUM_P_BITS    (SUM_P_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .ax         (ax),
      .ay         (ay),
      .az         (az),
      .pos        (pos),
      .sum_x_next (sum_x),
      .sum_y_next (sum_y),
      .sum_z_next (sum_z),
      .sum_p_next (sum_p)
   );

   swavg_out_stage #(
      .WINDOW_DEPTH  (WINDOW_DEPTH),
      .ACCEL_BITS    (ACCEL_BITS),
      .POSITION_BITS (POSITION_BITS),
      .SUM_A_BITS    (SUM_A_BITS),
      .SUM_P_BITS    (SUM_P_BITS)
   ) u_out (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .ready             (out_ready),
      .sum_x             (sum_x),
      .sum_y             (sum_y),
      .sum_z             (sum_z),
      .sum_p             (sum_p),
      .ax                (ax),
      .ay                (ay),
      .az                (az),
      .cfg               (cfg),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mean_x        (rsp_mean_x),
      .rsp_mean_y        (rsp_mean_y),
      .rsp_mean_z        (rsp_mean_z),
      .rsp_mean_position (rsp_mean_position),
      .rsp_free_fall     (rsp_free_fall)
   );

endmodule

### design/swavg_csr.sv
// configuration registers: free-fall axis and threshold
module swavg_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [swavg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [swavg_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output swavg_pkg::cfg_type                      cfg
);

   swavg_pkg::cfg_type cfg_ff;
   swavg_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            swavg_pkg::CSR_FREEFALL_AXIS: begin
               cfg_in.axis = swavg_pkg::axis_type'(csr_wdata[1:0]);
            end
            swavg_pkg::CSR_FREEFALL_THRESHOLD: begin
               cfg_in.threshold = csr_wdata[swavg_pkg::THRESHOLD_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis      <= swavg_pkg::AXIS_RESET;
         cfg_ff.threshold <= swavg_pkg::THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/swavg_in_stage.sv
// input register stage for sample beats
module swavg_in_stage #(
   parameter int ACCEL_BITS    = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [ACCEL_BITS-1:0]     req_accel_x,
   input  logic signed [ACCEL_BITS-1:0]     req_accel_y,
   input  logic signed [ACCEL_BITS-1:0]     req_accel_z,
   input  logic [POSITION_BITS-1:0]         req_position_ticks,
   input  logic                             next_ready,
   output logic                             advance,
   output logic signed [ACCEL_BITS-1:0]     ax,
   output logic signed [ACCEL_BITS-1:0]     ay,
   output logic signed [ACCEL_BITS-1:0]     az,
   output logic [POSITION_BITS-1:0]         pos
);

   logic                          valid_ff;
   logic                          valid_in;
   logic                          load;
   logic signed [ACCEL_BITS-1:0]  ax_ff;
   logic signed [ACCEL_BITS-1:0]  ay_ff;
   logic signed [ACCEL_BITS-1:0]  az_ff;
   logic [POSITION_BITS-1:0]      pos_ff;

   assign advance   = valid_ff && next_ready;
   assign req_stall = valid_ff && !next_ready;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !advance);

   assign ax  = ax_ff;
   assign ay  = ay_ff;
   assign az  = az_ff;
   assign pos = pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ax_ff  <= req_accel_x;
         ay_ff  <= req_accel_y;
         az_ff  <= req_accel_z;
         pos_ff <= req_position_ticks;
      end
   end

endmodule

### design/swavg_window.sv
// sample window shift line, fill count and running sums
module swavg_window #(
   parameter int WINDOW_DEPTH  = 16,
   parameter int ACCEL_BITS    = 16,
   parameter int POSITION_BITS = 32,
   parameter int SUM_A_BITS    = ACCEL_BITS + $clog2(WINDOW_DEPTH) + 1,
   parameter int SUM_P_BITS    = POSITION_BITS + $clog2(WINDOW_DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic signed [ACCEL_BITS-1:0]     ax,
   input  logic signed [ACCEL_BITS-1:0]     ay,
   input  logic signed [ACCEL_BITS-1:0]     az,
   input  logic [POSITION_BITS-1:0]         pos,
   output logic signed [SUM_A_BITS-1:0]     sum_x_next,
   output logic signed [SUM_A_BITS-1:0]     sum_y_next,
   output logic signed [SUM_A_BITS-1:0]     sum_z_next,
   output logic [SUM_P_BITS-1:0]            sum_p_next
);

   localparam int COUNT_BITS = $clog2(WINDOW_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(WINDOW_DEPTH);

   logic signed [ACCEL_BITS-1:0]  win_x_ff [WINDOW_DEPTH];
   logic signed [ACCEL_BITS-1:0]  win_y_ff [WINDOW_DEPTH];
   logic signed [ACCEL_BITS-1:0]  win_z_ff [WINDOW_DEPTH];
   logic [POSITION_BITS-1:0]      win_p_ff [WINDOW_DEPTH];

   logic [COUNT_BITS-1:0]         count_ff;
   logic [COUNT_BITS-1:0]         count_in;
   logic signed [SUM_A_BITS-1:0]  sum_x_ff;
   logic signed [SUM_A_BITS-1:0]  sum_y_ff;
   logic signed [SUM_A_BITS-1:0]  sum_z_ff;
   logic [SUM_P_BITS-1:0]         sum_p_ff;

   logic                          full;
   logic signed [ACCEL_BITS-1:0]  old_x;
   logic signed [ACCEL_BITS-1:0]  old_y;
   logic signed [ACCEL_BITS-1:0]  old_z;
   logic [POSITION_BITS-1:0]      old_p;

   // oldest entry counts as zero until the window has filled once
   assign full  = (count_ff == FULL_COUNT);
   assign old_x = full ? win_x_ff[WINDOW_DEPTH-1] : '0;
   assign old_y = full ? win_y_ff[WINDOW_DEPTH-1] : '0;
   assign old_z = full ? win_z_ff[WINDOW_DEPTH-1] : '0;
   assign old_p = full ? win_p_ff[WINDOW_DEPTH-1] : '0;

   assign sum_x_next = sum_x_ff + SUM_A_BITS'(ax) - SUM_A_BITS'(old_x);
   assign sum_y_next = sum_y_ff + SUM_A_BITS'(ay) - SUM_A_BITS'(old_y);
   assign sum_z_next = sum_z_ff + SUM_A_BITS'(az) - SUM_A_BITS'(old_z);
   assign sum_p_next = sum_p_ff + SUM_P_BITS'(pos) - SUM_P_BITS'(old_p);

   assign count_in = full ? count_ff : count_ff + COUNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
         sum_p_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
         sum_x_ff <= sum_x_next;
         sum_y_ff <= sum_y_next;
         sum_z_ff <= sum_z_next;
         sum_p_ff <= sum_p_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         win_x_ff[0] <= ax;
         win_y_ff[0] <= ay;
         win_z_ff[0] <= az;
         win_p_ff[0] <= pos;
         for (int i = 1; i < WINDOW_DEPTH; i++) begin
            win_x_ff[i] <= win_x_ff[i-1];
            win_y_ff[i] <= win_y_ff[i-1];
            win_z_ff[i] <= win_z_ff[i-1];
            win_p_ff[i] <= win_p_ff[i-1];
         end
      end
   end

endmodule

### design/swavg_out_stage.sv
// mean scaling, free-fall compare and result register
module swavg_out_stage #(
   parameter int WINDOW_DEPTH  = 16,
   parameter int ACCEL_BITS    = 16,
   parameter int POSITION_BITS = 32,
   parameter int SUM_A_BITS    = ACCEL_BITS + $clog2(WINDOW_DEPTH) + 1,
   parameter int SUM_P_BITS    = POSITION_BITS + $clog2(WINDOW_DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   output logic                             ready,
   input  logic signed [SUM_A_BITS-1:0]     sum_x,
   input  logic signed [SUM_A_BITS-1:0]     sum_y,
   input  logic signed [SUM_A_BITS-1:0]     sum_z,
   input  logic [SUM_P_BITS-1:0]            sum_p,
   input  logic signed [ACCEL_BITS-1:0]     ax,
   input  logic signed [ACCEL_BITS-1:0]     ay,
   input  logic signed [ACCEL_BITS-1:0]     az,
   input  swavg_pkg::cfg_type               cfg,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [ACCEL_BITS-1:0]     rsp_mean_x,
   output logic signed [ACCEL_BITS-1:0]     rsp_mean_y,
   output logic signed [ACCEL_BITS-1:0]     rsp_mean_z,
   output logic [POSITION_BITS-1:0]         rsp_mean_position,
   output logic                             rsp_free_fall
);

   // floor(log2(depth))
   localparam int SHIFT = $clog2(WINDOW_DEPTH + 1) - 1;
   localparam int CMP_BITS =
      (ACCEL_BITS > swavg_pkg::THRESHOLD_BITS) ? ACCEL_BITS : swavg_pkg::THRESHOLD_BITS;
   localparam logic signed [SUM_A_BITS-1:0] MEAN_MAX =
      {{(SUM_A_BITS-ACCEL_BITS+1){1'b0}}, {(ACCEL_BITS-1){1'b1}}};
   localparam logic signed [SUM_A_BITS-1:0] MEAN_MIN = ~MEAN_MAX;

   logic                          valid_ff;
   logic                          valid_in;
   logic signed [ACCEL_BITS-1:0]  mean_x_ff;
   logic signed [ACCEL_BITS-1:0]  mean_y_ff;
   logic signed [ACCEL_BITS-1:0]  mean_z_ff;
   logic [POSITION_BITS-1:0]      mean_p_ff;
   logic                          free_fall_ff;

   logic signed [SUM_A_BITS-1:0]  shr_x;
   logic signed [SUM_A_BITS-1:0]  shr_y;
   logic signed [SUM_A_BITS-1:0]  shr_z;
   logic [SUM_P_BITS-1:0]         shr_p;
   logic signed [ACCEL_BITS-1:0]  mean_x_in;
   logic signed [ACCEL_BITS-1:0]  mean_y_in;
   logic signed [ACCEL_BITS-1:0]  mean_z_in;
   logic [POSITION_BITS-1:0]      mean_p_in;
   logic signed [CMP_BITS-1:0]    chk;
   logic signed [CMP_BITS-1:0]    thr;
   logic                          free_fall_in;

   function automatic logic signed [ACCEL_BITS-1:0] clamp(
      input logic signed [SUM_A_BITS-1:0] v
   );
      logic signed [ACCEL_BITS-1:0] r;
      if (v > MEAN_MAX) begin
         r = MEAN_MAX[ACCEL_BITS-1:0];
      end else if (v < MEAN_MIN) begin
         r = MEAN_MIN[ACCEL_BITS-1:0];
      end else begin
         r = v[ACCEL_BITS-1:0];
      end
      return r;
   endfunction

   assign shr_x = sum_x >>> SHIFT;
   assign shr_y = sum_y >>> SHIFT;
   assign shr_z = sum_z >>> SHIFT;
   assign shr_p = sum_p >> SHIFT;

   assign mean_x_in = clamp(shr_x);
   assign mean_y_in = clamp(shr_y);
   assign mean_z_in = clamp(shr_z);
   assign mean_p_in = (|shr_p[SUM_P_BITS-1:POSITION_BITS]) ? '1 : shr_p[POSITION_BITS-1:0];

   always_comb begin
      thr = CMP_BITS'(cfg.threshold);
      case (cfg.axis)
         swavg_pkg::AXIS_X: chk = CMP_BITS'(ax);
         swavg_pkg::AXIS_Y: chk = CMP_BITS'(ay);
         swavg_pkg::AXIS_Z: chk = CMP_BITS'(az);
         default:           chk = '0;
      endcase
      free_fall_in = (cfg.axis != swavg_pkg::AXIS_NONE) && (chk < thr);
   end

   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = advance || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mean_x_ff    <= mean_x_in;
         mean_y_ff    <= mean_y_in;
         mean_z_ff    <= mean_z_in;
         mean_p_ff    <= mean_p_in;
         free_fall_ff <= free_fall_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_mean_x        = mean_x_ff;
   assign rsp_mean_y        = mean_y_ff;
   assign rsp_mean_z        = mean_z_ff;
   assign rsp_mean_position = mean_p_ff;
   assign rsp_free_fall     = free_fall_ff;

endmodule

### design/swavg_checker.sv
// port-level checks for the sample window averager, bound to the top level
module swavg_checker #(
   parameter int ACCEL_BITS    = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_stall,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [ACCEL_BITS-1:0]     rsp_mean_x,
   input  logic [POSITION_BITS-1:0]         rsp_mean_position,
   input  logic                             rsp_free_fall,
   input  logic                             csr_ready
);

   // a held result beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mean_x)
         && $stable(rsp_mean_position) && $stable(rsp_free_fall))
      else $error("stalled rsp beat changed");

   // input backs up only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without rsp backpressure");

   // both stages empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // config port never backs up
   assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr not ready");

endmodule

bind sample_window_average_freefall_top swavg_checker #(
   .ACCEL_BITS    (ACCEL_BITS),
   .POSITION_BITS (POSITION_BITS)
) u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_mean_x        (rsp_mean_x),
   .rsp_mean_position (rsp_mean_position),
   .rsp_free_fall     (rsp_free_fall),
   .csr_ready         (csr_ready)
);
